// ===== rtl/core/pdsc_pkg.sv =====
// Shared types and constants of the pair detour service check.
package pdsc_pkg;

  // Field widths
  localparam int DIST_W   = 32;
  localparam int FRAC_W   = 16;
  localparam int RATIO_W  = 32;
  localparam int PAIRS_W  = 11;
  localparam int STRAND_W = 7;
  localparam int CCOUNT_W = 7;
  localparam int REG_IDX_W = 2;
  localparam int REG_DATA_W = 32;

  // Radix-2 divider: one quotient bit a cycle
  localparam int DIV_STEPS = RATIO_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

  localparam logic [RATIO_W-1:0]  RATIO_ALL  = '1;
  localparam logic [RATIO_W-1:0]  RATIO_INIT = 32'h0002_0000;
  localparam logic [PAIRS_W-1:0]  PAIRS_MAX  = '1;
  localparam logic [STRAND_W-1:0] STRAND_MAX = '1;

  // Configuration register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_CONNECTOR_COUNT = 2'd0,
    REG_MAX_DETOUR      = 2'd1,
    REG_MIN_DISTANCE    = 2'd2
  } reg_index_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_t;

endpackage

// ===== rtl/core/pdsc_cell_if.sv =====
// Input channel: one matrix cell per item.
interface pdsc_cell_if import pdsc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] network_dist;
  logic              network_finite;
  logic [DIST_W-1:0] geodesic_dist;
  logic              geodesic_finite;
  logic              pair_relevant;
  logic              row_on_ring;
  logic              col_on_ring;

  modport source (
    output valid, network_dist, network_finite, geodesic_dist, geodesic_finite,
           pair_relevant, row_on_ring, col_on_ring,
    input  ready
  );

  modport sink (
    input  valid, network_dist, network_finite, geodesic_dist, geodesic_finite,
           pair_relevant, row_on_ring, col_on_ring,
    output ready
  );
endinterface

// ===== rtl/core/pdsc_result_if.sv =====
// Output channel: pair results and verdicts.
interface pdsc_result_if import pdsc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                result_kind;
  logic [RATIO_W-1:0]  detour;
  logic                detour_infinite;
  logic [PAIRS_W-1:0]  relevant_count;
  logic [STRAND_W-1:0] stranded_count;
  logic [RATIO_W-1:0]  worst_detour;
  logic                worst_infinite;
  logic                served;

  modport source (
    output valid, result_kind, detour, detour_infinite, relevant_count,
           stranded_count, worst_detour, worst_infinite, served,
    input  ready
  );

  modport sink (
    input  valid, result_kind, detour, detour_infinite, relevant_count,
           stranded_count, worst_detour, worst_infinite, served,
    output ready
  );
endinterface

// ===== rtl/core/pdsc_div.sv =====
// Bit-serial restoring divider: (num << 16) / den, for quotients below 2^32.
module pdsc_div import pdsc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DIST_W-1:0]  num,
  input  logic [DIST_W-1:0]  den,
  output logic               done,
  output logic [RATIO_W-1:0] quo
);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [DIST_W-1:0] rem;
  logic [DIST_W-1:0] dq;   // dividend bits shift out at the top, quotient bits in at the bottom
  logic [DIST_W-1:0] dvs;

  logic [DIST_W:0] trial;
  logic [DIST_W:0] diff;
  logic            fits;

  // One restoring step
  assign trial = {rem, dq[DIST_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = (trial >= {1'b0, dvs});

  // Step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + STEP_W'(1);
      if (step == STEP_LAST) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath; the caller guarantees num[31:16] < den, so the quotient fits in 32 bits
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= {{(DIST_W-FRAC_W){1'b0}}, num[DIST_W-1:FRAC_W]};
      dq  <= {num[FRAC_W-1:0], {(DIST_W-FRAC_W){1'b0}}};
      dvs <= den;
    end else if (busy) begin
      rem <= fits ? diff[DIST_W-1:0] : trial[DIST_W-1:0];
      dq  <= {dq[DIST_W-2:0], fits};
    end
  end

  assign done = busy && (step == STEP_LAST);
  assign quo  = dq;

endmodule

// ===== rtl/core/pair_detour_service_check.sv =====
// Pair detour service check: top level with scan bookkeeping and output register.
//
// Cells of the k by k connector-pair matrix arrive row-major, one per item; the block
// tracks row and column itself. A cell that yields a finite, unsaturated detour ratio
// is accepted, run through the bit-serial radix-2 divider, then loaded into the
// output register. A cell whose ratio is infinite or saturated, and a last cell that
// carries the verdict without a division, go from acceptance straight to the output
// register; all other cells are only accepted. A finished item waits in the output
// register while the next cell is accepted; the block holds a new result only while
// the previous one has not been taken. Writing connector_count restarts the scan.
module pair_detour_service_check import pdsc_pkg::*; #(
  parameter int MAX_CONNECTORS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  pdsc_cell_if.sink             cells,
  pdsc_result_if.source         results,
  input  logic                  wr_en,
  input  logic [REG_IDX_W-1:0]  wr_index,
  input  logic [REG_DATA_W-1:0] wr_data
);

  localparam int IW  = $clog2(MAX_CONNECTORS);
  localparam int KB  = $clog2(MAX_CONNECTORS + 1);
  localparam int KW  = (KB > CCOUNT_W) ? KB : CCOUNT_W;
  localparam logic [KW-1:0] K_MAX = KW'(MAX_CONNECTORS);

  // Configuration
  logic [KW-1:0]      k_eff;
  logic [RATIO_W-1:0] max_ratio;
  logic [DIST_W-1:0]  min_dist;

  // Scan state
  state_t              state, state_next;
  logic [IW-1:0]       row, col;
  logic                row_reachable;
  logic [PAIRS_W-1:0]  pair_total;
  logic [STRAND_W-1:0] stranded_total;
  logic [RATIO_W-1:0]  worst_ratio;
  logic                worst_inf;

  // Pending result of the accepted cell
  logic                p_kind;
  logic                p_inf;
  logic                p_sat;
  logic [PAIRS_W-1:0]  p_pairs;
  logic [STRAND_W-1:0] p_stranded;
  logic [RATIO_W-1:0]  p_worst;
  logic                p_worst_inf;
  logic                p_served;

  // Output register
  logic out_valid;

  // Handshake and sequencing controls
  logic accept;
  logic div_start;
  logic emit_go;
  logic div_done;
  logic [RATIO_W-1:0] quo;

  // Per-cell decode
  logic [KW-1:0]       cc_wide;
  logic [KW-1:0]       k_new;
  logic                last_col, last_row;
  logic                is_pair, is_inf, is_sat, need_div, is_final;
  logic                reach_new, strand_inc;
  logic [STRAND_W-1:0] stranded_new;
  logic [PAIRS_W-1:0]  pairs_new;
  logic                ok;
  logic [RATIO_W-1:0]  det_val;
  logic [RATIO_W-1:0]  worst_upd;

  // Effective connector count of a write
  always_comb begin
    cc_wide = KW'(wr_data[CCOUNT_W-1:0]);
    k_new   = cc_wide;
    if (cc_wide == '0) begin
      k_new = KW'(1);
    end else if (cc_wide > K_MAX) begin
      k_new = K_MAX;
    end
  end

  // Cell decode
  always_comb begin
    last_col  = ((KW'(col) + KW'(1)) == k_eff);
    last_row  = ((KW'(row) + KW'(1)) == k_eff);
    is_final  = last_col && last_row;
    is_pair   = (col > row) && cells.pair_relevant && cells.geodesic_finite &&
                (cells.geodesic_dist >= min_dist) && cells.row_on_ring && cells.col_on_ring;
    is_inf    = !cells.network_finite || (cells.geodesic_dist == '0);
    is_sat    = ({{(DIST_W-FRAC_W){1'b0}}, cells.network_dist[DIST_W-1:FRAC_W]}
                 >= cells.geodesic_dist);
    need_div  = is_pair && !is_inf && !is_sat;
    reach_new = row_reachable || ((col != row) && cells.network_finite);
    strand_inc = last_col && !cells.row_on_ring && !reach_new && (stranded_total != STRAND_MAX);
    stranded_new = strand_inc ? stranded_total + STRAND_W'(1) : stranded_total;
    pairs_new = (is_pair && (pair_total != PAIRS_MAX)) ? pair_total + PAIRS_W'(1)
                                                       : pair_total;
    ok = !worst_inf && (worst_ratio <= max_ratio) && (stranded_new == '0);
  end

  // Ratio of the pending pair and the worst ratio after it
  assign det_val   = (p_inf || p_sat) ? RATIO_ALL : quo;
  assign worst_upd = (!worst_inf && (det_val > worst_ratio)) ? det_val : worst_ratio;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (need_div) begin
            state_next = ST_DIV;
          end else if (is_pair || is_final) begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid || results.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    cells.ready = (state == ST_IDLE);
    accept      = (state == ST_IDLE) && cells.valid;
    div_start   = accept && need_div;
    emit_go     = (state == ST_EMIT) && (!out_valid || results.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      k_eff     <= KW'(1);
      max_ratio <= RATIO_INIT;
      min_dist  <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_CONNECTOR_COUNT: k_eff     <= k_new;
        REG_MAX_DETOUR:      max_ratio <= wr_data[RATIO_W-1:0];
        REG_MIN_DISTANCE:    min_dist  <= wr_data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // Scan bookkeeping and accumulators
  always_ff @(posedge clk) begin
    if (rst || (wr_en && (wr_index == REG_CONNECTOR_COUNT))) begin
      row            <= '0;
      col            <= '0;
      row_reachable  <= 1'b0;
      pair_total     <= '0;
      stranded_total <= '0;
      worst_ratio    <= '0;
      worst_inf      <= 1'b0;
    end else if (accept) begin
      if (is_final) begin
        row            <= '0;
        col            <= '0;
        row_reachable  <= 1'b0;
        pair_total     <= '0;
        stranded_total <= '0;
        worst_ratio    <= '0;
        worst_inf      <= 1'b0;
      end else begin
        pair_total     <= pairs_new;
        stranded_total <= stranded_new;
        if (last_col) begin
          row           <= row + IW'(1);
          col           <= '0;
          row_reachable <= 1'b0;
        end else begin
          col           <= col + IW'(1);
          row_reachable <= reach_new;
        end
        if (is_pair && is_inf) begin
          worst_inf   <= 1'b1;
          worst_ratio <= RATIO_ALL;
        end
      end
    end else if (emit_go && !p_kind) begin
      worst_ratio <= worst_upd;
    end
  end

  // Snapshot of the accepted cell's result
  always_ff @(posedge clk) begin
    if (accept) begin
      p_kind      <= is_final;
      p_inf       <= is_inf;
      p_sat       <= is_sat;
      p_pairs     <= is_final ? pair_total : pairs_new;
      p_stranded  <= is_final ? stranded_new : stranded_total;
      p_worst     <= worst_ratio;
      p_worst_inf <= worst_inf;
      p_served    <= ok;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      results.result_kind     <= p_kind;
      results.detour          <= p_kind ? '0 : det_val;
      results.detour_infinite <= p_kind ? 1'b0 : p_inf;
      results.relevant_count  <= p_pairs;
      results.stranded_count  <= p_stranded;
      results.worst_detour    <= p_kind ? p_worst : worst_upd;
      results.worst_infinite  <= p_kind ? p_worst_inf : worst_inf;
      results.served          <= p_kind ? p_served : 1'b0;
    end
  end

  assign results.valid = out_valid;

  // Ratio divider
  pdsc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (cells.network_dist),
    .den   (cells.geodesic_dist),
    .done  (div_done),
    .quo   (quo)
  );

endmodule
